// ----- rtl/core/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and the round constant table of the hash engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_CHAIN = 8;
  localparam int unsigned NUM_SCHED = 16;
  localparam int unsigned LEN_W     = 64;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ROUND_W   = 6;
  localparam int unsigned OUT_IDX_W = 3;
  localparam int unsigned VB_W      = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [VB_W-1:0]      VB_FULL      = 3'd4;
  localparam logic [WORD_W-1:0]    MARK_WORD    = 32'h8000_0000;
  localparam logic [SLOT_W-1:0]    SLOT_LEN_HI  = 4'd14;
  localparam logic [SLOT_W-1:0]    SLOT_LAST    = 4'd15;
  localparam logic [ROUND_W-1:0]   LAST_ROUND   = 6'd63;
  localparam logic [OUT_IDX_W-1:0] LAST_OUT_IDX = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] msg_word;
    logic [VB_W-1:0]   valid_bytes;
    logic              final_word;
  } sha256_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic              digest_last;
  } sha256_out_t;

  // source of a word shifted into the schedule window
  typedef enum logic [2:0] {
    SRC_INPUT  = 3'd0,
    SRC_MARK   = 3'd1,
    SRC_ZERO   = 3'd2,
    SRC_LEN_HI = 3'd3,
    SRC_LEN_LO = 3'd4
  } push_src_t;

  typedef struct packed {
    logic                 start;
    logic                 push;
    push_src_t            push_src;
    logic                 round;
    logic [ROUND_W-1:0]   round_idx;
    logic                 fold;
    logic                 out_load;
    logic [OUT_IDX_W-1:0] out_idx;
  } sha256_cmd_t;

  typedef struct packed {
    logic slot_at_len;
    logic slot_last;
    logic vb_full;
  } sha256_sts_t;

  function automatic logic [WORD_W-1:0] std_iv(input logic [CFG_IDX_W-1:0] idx);
    logic [WORD_W-1:0] v;
    case (idx)
      3'd0:    v = 32'h6A09E667;
      3'd1:    v = 32'hBB67AE85;
      3'd2:    v = 32'h3C6EF372;
      3'd3:    v = 32'hA54FF53A;
      3'd4:    v = 32'h510E527F;
      3'd5:    v = 32'h9B05688C;
      3'd6:    v = 32'h1F83D9AB;
      default: v = 32'h5BE0CD19;
    endcase
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    case (idx)
      6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF; 6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98; 6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;
      default: k = 32'hC67178F2;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/sha256_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_dpath
// Start-value registers, chaining value, round variables, schedule window,
// length counter and digest output register.
// ----------------------------------------------------------------------------
module sha256_dpath
  import sha256_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_cmd_t          cmd,
  output sha256_sts_t          sts,
  input  sha256_in_t           in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  output sha256_out_t          out_data
);

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                             input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  logic [WORD_W-1:0] iv_r    [NUM_CHAIN];
  logic [WORD_W-1:0] chain_r [NUM_CHAIN];
  logic [WORD_W-1:0] var_r   [NUM_CHAIN];
  logic [WORD_W-1:0] win_r   [NUM_SCHED];
  logic [LEN_W-1:0]  len_r;
  logic [SLOT_W-1:0] slot_r;
  sha256_out_t       out_r;

  logic [VB_W-1:0]   vb_sat;
  logic [WORD_W-1:0] first_word;
  logic [LEN_W-1:0]  len_add;
  logic [LEN_W-1:0]  len_base;
  logic [SLOT_W-1:0] slot_base;
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] sched_new;
  logic [WORD_W-1:0] t1;
  logic [WORD_W-1:0] t2;
  logic              blk_done;

  assign vb_sat    = (in_data.valid_bytes > VB_FULL) ? VB_FULL : in_data.valid_bytes;
  assign len_base  = cmd.start ? '0 : len_r;
  assign slot_base = cmd.start ? '0 : slot_r;
  assign blk_done  = cmd.push && (slot_base == SLOT_LAST);

  // keep the valid leading bytes and append the marker byte
  always_comb begin
    first_word = in_data.msg_word;
    if (in_data.final_word && (vb_sat != VB_FULL)) begin
      case (vb_sat[1:0])
        2'd0:    first_word = MARK_WORD;
        2'd1:    first_word = {in_data.msg_word[31:24], 8'h80, 16'h0000};
        2'd2:    first_word = {in_data.msg_word[31:16], 8'h80, 8'h00};
        default: first_word = {in_data.msg_word[31:8], 8'h80};
      endcase
    end
  end

  assign len_add = in_data.final_word ? {{(LEN_W-VB_W-3){1'b0}}, vb_sat, 3'b000}
                                      : LEN_W'(WORD_W);

  always_comb begin
    case (cmd.push_src)
      SRC_INPUT:  push_word = first_word;
      SRC_MARK:   push_word = MARK_WORD;
      SRC_LEN_HI: push_word = len_r[LEN_W-1:WORD_W];
      SRC_LEN_LO: push_word = len_r[WORD_W-1:0];
      default:    push_word = '0;
    endcase
  end

  assign sched_new = ssig1(win_r[14]) + win_r[9] + ssig0(win_r[1]) + win_r[0];
  assign t1 = var_r[7] + bsig1(var_r[4]) + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
            + round_k(cmd.round_idx) + win_r[0];
  assign t2 = bsig0(var_r[0])
            + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  assign sts.slot_at_len = (slot_base == SLOT_LEN_HI);
  assign sts.slot_last   = (slot_base == SLOT_LAST);
  assign sts.vb_full     = (vb_sat == VB_FULL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        iv_r[i] <= std_iv(CFG_IDX_W'(i));
      end
    end else if (cfg_we) begin
      iv_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      slot_r <= '0;
    end else begin
      if (cmd.push) begin
        slot_r <= slot_base + 1'b1;
      end
      if (cmd.push && (cmd.push_src == SRC_INPUT)) begin
        len_r <= len_base + len_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHAIN; i++) begin
      if (cmd.start) begin
        chain_r[i] <= iv_r[i];
      end else if (cmd.fold) begin
        chain_r[i] <= chain_r[i] + var_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (blk_done) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        var_r[i] <= chain_r[i];
      end
    end else if (cmd.round) begin
      var_r[0] <= t1 + t2;
      var_r[1] <= var_r[0];
      var_r[2] <= var_r[1];
      var_r[3] <= var_r[2];
      var_r[4] <= var_r[3] + t1;
      var_r[5] <= var_r[4];
      var_r[6] <= var_r[5];
      var_r[7] <= var_r[6];
    end
  end

  // window slides by one word per push or per round
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[NUM_SCHED-1] <= cmd.push ? push_word : sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.digest_word <= chain_r[cmd.out_idx];
      out_r.digest_last <= (cmd.out_idx == LAST_OUT_IDX);
    end
  end

  assign out_data = out_r;

endmodule

// ----- rtl/core/sha256_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: request intake, padding steps, round count and digest readout.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_final,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sha256_sts_t sts,
  output sha256_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } ctrl_state_t;

  typedef enum logic [4:0] {
    PH_NONE   = 5'b00001,
    PH_MARK   = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_LEN_LO = 5'b01000,
    PH_DONE   = 5'b10000
  } pad_phase_t;

  ctrl_state_t          state_r,     state_nxt;
  pad_phase_t           phase_r,     phase_nxt;
  logic                 busy_r,      busy_nxt;
  logic [ROUND_W-1:0]   round_r,     round_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r,   out_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    busy_nxt    = busy_r;
    round_nxt   = round_r;
    out_idx_nxt = out_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.push     = 1'b1;
          cmd.push_src = SRC_INPUT;
          cmd.start    = !busy_r;
          busy_nxt     = 1'b1;
          if (in_final) begin
            phase_nxt = sts.vb_full ? PH_MARK : PH_ZERO;
          end
          if (sts.slot_last) begin
            state_nxt = ST_ROUND;
            round_nxt = '0;
          end else if (in_final) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        cmd.round     = 1'b1;
        cmd.round_idx = round_r;
        round_nxt     = round_r + 1'b1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (phase_r == PH_NONE) begin
          state_nxt = ST_IDLE;
        end else if (phase_r == PH_DONE) begin
          state_nxt   = ST_OUT;
          out_idx_nxt = '0;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        unique case (phase_r)
          PH_MARK: begin
            cmd.push     = 1'b1;
            cmd.push_src = SRC_MARK;
            phase_nxt    = PH_ZERO;
          end
          PH_ZERO: begin
            cmd.push = 1'b1;
            if (sts.slot_at_len) begin
              cmd.push_src = SRC_LEN_HI;
              phase_nxt    = PH_LEN_LO;
            end else begin
              cmd.push_src = SRC_ZERO;
            end
          end
          PH_LEN_LO: begin
            cmd.push     = 1'b1;
            cmd.push_src = SRC_LEN_LO;
            phase_nxt    = PH_DONE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
        if (cmd.push && sts.slot_last) begin
          state_nxt = ST_ROUND;
          round_nxt = '0;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          cmd.out_idx  = out_idx_r;
          out_idx_nxt  = out_idx_r + 1'b1;
          if (out_idx_r == LAST_OUT_IDX) begin
            state_nxt = ST_IDLE;
            phase_nxt = PH_NONE;
            busy_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_NONE;
      busy_r      <= 1'b0;
      round_r     <= '0;
      out_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      round_r     <= round_nxt;
      out_idx_r   <= out_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/sha256_hash_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a stream of big-endian 32-bit words with byte-exact length,
// programmable start value and eight-word digest readout.
// ----------------------------------------------------------------------------
// intake: 16 words go in one per cycle while in_stall is low, then 64 rounds on the
//   shared round unit and a fold; in_stall holds off new words during the rounds and the fold
// finish: after the final request up to 18 padding words go in one per cycle,
//   with one or two compressions, then eight digest words leave
//   one per cycle while out_stall is low
// reset: synchronous, active low; standard iv back in the start values, idle
// ----------------------------------------------------------------------------
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  // message requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_in_t           in_data,

  // digest words
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_out_t          out_data,

  // start value write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  // command and status between sequencer and datapath
  sha256_cmd_t cmd;
  sha256_sts_t sts;

  // sequencer: intake, padding order, round count, digest readout
  sha256_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.final_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: window, round unit, chaining value, length and output register
  sha256_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

// ----- verif/sha256_hash_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine_tb
// Self-checking bench for the SHA-256 engine. Messages are streamed in as
// word requests with random gaps and output stalls. A behavioral SHA-256
// model inside the bench predicts the eight digest words of every message,
// and a monitor compares each digest word as it leaves the engine. Start
// values are switched between the standard IV, all zeros, all ones and a
// random midstate between traffic phases.
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb;
  import sha256_pkg::*;

  typedef logic [WORD_W-1:0] word_t;

  // start value sets loaded between phases
  typedef enum int {
    IV_SET_STANDARD,
    IV_SET_ZERO,
    IV_SET_ONES,
    IV_SET_RANDOM
  } iv_set_t;

  localparam int CLK_HALF_NS   = 2;
  localparam int RESET_CYCLES  = 5;
  // engine is idle once the last digest word is out, a short margin is plenty
  localparam int SETTLE_CYCLES = 20;
  // far beyond the slowest legal run
  localparam int TIMEOUT_NS    = 1_600_000;

  localparam word_t IV_STANDARD [0:7] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t K_ROUND [0:63] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // dut ports, all inputs known from time zero
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  sha256_in_t           in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sha256_out_t          out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  word_t                cfg_wdata = '0;

  // hash model state
  word_t             iv_shadow [NUM_CHAIN];
  word_t             chain_h   [NUM_CHAIN];
  word_t             sched_w   [NUM_SCHED];
  logic [LEN_W-1:0]  msg_bits;
  int unsigned       blk_slot;
  bit                in_msg;

  // digest words still owed by the engine, oldest first
  sha256_out_t       digest_q [$];

  int                mismatch_cnt   = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;

  sha256_hash_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // hash model
  // --------------------------------------------------------------------------

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  // 64 rounds over the current 16-word block, then fold into the chain
  function automatic void compress_block();
    word_t v [8];
    word_t w, s1, ch, t1, s0, mj, t2, x2, x15;
    for (int j = 0; j < 8; j++) v[j] = chain_h[j];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w = sched_w[r];
      end else begin
        // schedule expands in place over a 16-word window
        x2  = sched_w[(r - 2) & 15];
        x15 = sched_w[(r - 15) & 15];
        w = (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10))
          + sched_w[(r - 7) & 15]
          + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
          + sched_w[r & 15];
        sched_w[r & 15] = w;
      end
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + K_ROUND[r] + w;
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
  endfunction

  function automatic void push_block_word(input word_t w);
    sched_w[blk_slot] = w;
    blk_slot++;
    if (blk_slot == NUM_SCHED) begin
      compress_block();
      blk_slot = 0;
    end
  endfunction

  // advance the model by one accepted request, queue digest words on a final
  function automatic void predict_request(input sha256_in_t req);
    int unsigned vb;
    word_t       keep;
    if (!in_msg) begin
      // first word of a message picks up the current start values
      for (int j = 0; j < NUM_CHAIN; j++) chain_h[j] = iv_shadow[j];
      msg_bits = '0;
      blk_slot = 0;
      in_msg   = 1'b1;
    end
    if (!req.final_word) begin
      // valid_bytes means nothing on a non-final word
      msg_bits = msg_bits + 64'd32;
      push_block_word(req.msg_word);
      return;
    end
    vb = 32'((req.valid_bytes > VB_FULL) ? VB_FULL : req.valid_bytes);
    msg_bits = msg_bits + LEN_W'(8 * vb);
    if (vb == VB_FULL) begin
      push_block_word(req.msg_word);
      push_block_word(MARK_WORD);
    end else begin
      // trailing bytes are dropped and the marker byte follows the last kept one
      keep = (vb == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * vb));
      push_block_word((req.msg_word & keep) | (32'h80 << (24 - 8 * vb)));
    end
    // no room for the length in this block: pad it out and start another
    if (blk_slot > SLOT_LEN_HI) begin
      while (blk_slot != 0) push_block_word('0);
    end
    while (blk_slot < SLOT_LEN_HI) push_block_word('0);
    push_block_word(msg_bits[63:32]);
    push_block_word(msg_bits[31:0]);
    for (int k = 0; k < NUM_CHAIN; k++) begin
      digest_q.push_back('{digest_word: chain_h[k],
                           digest_last: (k == NUM_CHAIN - 1)});
    end
    in_msg   = 1'b0;
    msg_bits = '0;
    blk_slot = 0;
  endfunction

  // --------------------------------------------------------------------------
  // digest monitor
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    sha256_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h (last %b)",
               out_data.digest_word, out_data.digest_last);
        mismatch_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word) begin
          $error("digest_word expected %h got %h",
                 want.digest_word, out_data.digest_word);
          mismatch_cnt++;
        end
        if (out_data.digest_last !== want.digest_last) begin
          $error("digest_last expected %b got %b",
                 want.digest_last, out_data.digest_last);
          mismatch_cnt++;
        end
      end
    end
  end

  // receiver backpressure, one decision per cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // mostly random words, with the all-zero and all-one extremes mixed in
  function automatic word_t pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one word request; returns at the rising edge that accepted it
  task automatic send_word(input word_t w, input logic [VB_W-1:0] vb,
                           input logic fin);
    sha256_in_t req;
    req = '{msg_word: w, valid_bytes: vb, final_word: fin};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predict_request(req);
  endtask

  // drop valid and hold off until every owed digest word has left
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // load all eight start values, back to back, engine idle
  task automatic load_iv_set(input iv_set_t set_sel);
    word_t val;
    for (int i = 0; i < NUM_CHAIN; i++) begin
      case (set_sel)
        IV_SET_ZERO: val = '0;
        IV_SET_ONES: val = '1;
        IV_SET_RANDOM: val = $urandom;
        default: val = IV_STANDARD[i];
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= val;
      iv_shadow[i] = val;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // single-word messages: empty, partial words with junk tail, saturating counts
  task automatic test_short_messages();
    send_word($urandom, 3'd0, 1'b1);             // empty message, padding only
    send_word(32'h616263A5, 3'd3, 1'b1);         // "abc" with a junk trailing byte
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, VB_FULL, 1'b1);
    send_word($urandom, 3'd5, 1'b1);             // oversized counts act as four
    send_word(32'h0000_0000, 3'd7, 1'b1);
  endtask

  // full word at slot 13 puts the marker in slot 14, leaving no room for the
  // length and forcing a second block; non-final words carry random byte
  // counts that must be ignored
  task automatic test_block_boundary();
    wait_drained();
    for (int i = 0; i < 13; i++) begin
      send_word(pick_word(), VB_W'($urandom_range(7)), 1'b0);
    end
    send_word(pick_word(), VB_FULL, 1'b1);
  endtask

  // random messages until the request budget is used up
  task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                    input int budget);
    int sent;
    int body_len;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < budget) begin
      // mostly one block, now and then a message of two or three blocks
      body_len = ($urandom_range(9) == 0) ? $urandom_range(18, 33)
                                          : $urandom_range(0, 16);
      for (int i = 0; i < body_len; i++) begin
        send_word(pick_word(), VB_W'($urandom_range(7)), 1'b0);
      end
      send_word(pick_word(), VB_W'($urandom_range(7)), 1'b1);
      sent += body_len + 1;
      // sender sometimes waits for the whole digest before the next message
      if ($urandom_range(4) == 0) wait_drained();
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NUM_CHAIN; i++) iv_shadow[i] = IV_STANDARD[i];
    msg_bits = '0;
    blk_slot = 0;
    in_msg   = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // standard start values straight out of reset, no idling
    test_short_messages();
    test_block_boundary();
    test_random_stream(0, 0, 20);

    load_iv_set(IV_SET_ZERO);
    test_random_stream(49, 0, 20);

    load_iv_set(IV_SET_ONES);
    test_random_stream(0, 49, 20);

    load_iv_set(IV_SET_RANDOM);
    test_random_stream(19, 19, 20);

    load_iv_set(IV_SET_STANDARD);
    test_random_stream(0, 0, 6);

    if (mismatch_cnt == 0) begin
      $display("sha256_hash_engine_tb: done, clean");
    end else begin
      $display("sha256_hash_engine_tb: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("sha256_hash_engine_tb: done, errors");
    $finish;
  end

endmodule
